@@ rtl/obl_pkg.sv @@
package obl_pkg;

    localparam int ORDER_SLOTS_DEF  = 1024;
    localparam int PRICE_LEVELS_DEF = 256;

    localparam logic [9:0] AGE_DIV  = 10'd1000;
    // ceil(2^36 / 1000): exact quotient for any 26-bit partial dividend
    localparam logic [26:0] AGE_RECIP  = 27'd68719477;
    localparam int          AGE_SHIFT  = 36;
    localparam int          DIV_CHUNKS = 4;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    typedef enum logic [2:0] {
        ACT_ADD       = 3'd0,
        ACT_MODIFY    = 3'd1,
        ACT_CANCEL    = 3'd2,
        ACT_TRADE     = 3'd3,
        ACT_RESET     = 3'd4,
        ACT_HEARTBEAT = 3'd5,
        ACT_QUERY     = 3'd6,
        ACT_UNKNOWN   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OSCAN,
        S_DECIDE,
        S_LSCAN,
        S_LREM,
        S_LPLACE,
        S_BEST,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_action     act;
        logic [63:0] ref_id;
        logic [1:0]  side;
        logic [31:0] px;
        logic [31:0] qty;
        logic [63:0] now;
        logic [7:0]  venue;
        logic [31:0] instr;
        logic        side_ok;
        logic        px_zero;
        logic        qty_zero;
        logic        add_bad;
    } t_item;

    typedef struct packed {
        logic [31:0] bid_px;
        logic [47:0] bid_qty;
        logic [31:0] ask_px;
        logic [47:0] ask_qty;
        logic [31:0] age_us;
        logic        crossed;
        t_status     status;
        logic [7:0]  venue;
        logic [31:0] instr;
    } t_result;

    typedef struct packed {
        logic [63:0] ref_id;
        logic [1:0]  side;
        logic [31:0] px;
        logic [31:0] qty;
    } t_slot;

    typedef struct packed {
        logic [31:0] px;
        logic [47:0] total;
    } t_level;

endpackage

@@ rtl/obl_front.sv @@
module obl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_action,
    input  logic [63:0]       i_order_ref,
    input  logic [1:0]        i_order_side,
    input  logic [31:0]       i_price_paise,
    input  logic [31:0]       i_quantity,
    input  logic [63:0]       i_time_ns,
    input  logic [7:0]        i_venue_code,
    input  logic [31:0]       i_instrument_code,
    output logic              o_valid,
    output obl_pkg::t_item    o_item,
    input  logic              i_take
);
    import obl_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       wr, rd;

    // decode and pre-check the request
    always_comb begin
        cls.act      = t_action'(i_action);
        cls.ref_id   = i_order_ref;
        cls.side     = i_order_side;
        cls.px       = i_price_paise;
        cls.qty      = i_quantity;
        cls.now      = i_time_ns;
        cls.venue    = i_venue_code;
        cls.instr    = i_instrument_code;
        cls.side_ok  = (i_order_side == SIDE_BUY) || (i_order_side == SIDE_SELL);
        cls.px_zero  = (i_price_paise == 32'd0);
        cls.qty_zero = (i_quantity == 32'd0);
        cls.add_bad  = (i_order_ref == 64'd0) || !cls.side_ok || cls.px_zero
                       || cls.qty_zero;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= cls;
    end

endmodule

@@ rtl/obl_div1000.sv @@
module obl_div1000 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    import obl_pkg::*;

    logic        r_busy;
    logic [2:0]  r_step;
    logic [63:0] r_dvd;
    logic [9:0]  r_rem;
    logic [15:0] r_digit;
    logic [31:0] r_quot;
    logic [25:0] part;
    logic [52:0] prod;
    logic [25:0] rem_full;

    // 16 dividend bits per chunk, MSB chunk first, each in an even and an odd step:
    // even step takes the quotient digit by reciprocal multiply,
    // odd step folds the remainder back and shifts in the digit
    assign part     = {r_rem, r_dvd[63:48]};
    assign prod     = 53'(part) * 53'(AGE_RECIP);
    assign rem_full = part - 26'(r_digit) * 26'(AGE_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == 3'(2 * DIV_CHUNKS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd   <= i_dividend;
            r_rem   <= '0;
            r_step  <= '0;
            r_quot  <= '0;
            r_digit <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (!r_step[0]) begin
                r_digit <= prod[AGE_SHIFT+15:AGE_SHIFT];
            end else begin
                r_rem  <= rem_full[9:0];
                r_quot <= {r_quot[15:0], r_digit};
                r_dvd  <= {r_dvd[47:0], 16'd0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

@@ rtl/obl_back.sv @@
module obl_back #(
    parameter int ORDER_SLOTS  = obl_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = obl_pkg::PRICE_LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  obl_pkg::t_item    i_item,
    output logic              o_take,
    input  logic              i_res_ready,
    output logic              o_emit,
    output obl_pkg::t_result  o_res
);
    import obl_pkg::*;

    localparam int SAW  = $clog2(ORDER_SLOTS);
    localparam int LAW  = $clog2(PRICE_LEVELS);
    localparam int MAXN = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
    localparam int MAXW = $clog2(MAXN);
    localparam int CNTW = $clog2(MAXN + 1);

    t_slot  slot_mem [ORDER_SLOTS];
    t_level bid_mem  [PRICE_LEVELS];
    t_level ask_mem  [PRICE_LEVELS];
    t_slot  slot_rd;
    t_level bid_rd, ask_rd;

    t_state r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_rd_v;
    logic [MAXW-1:0] r_rd_idx;
    t_item           r_item, n_item;
    logic            r_found, n_found, r_free_ok, n_free_ok;
    logic [SAW-1:0]  r_fidx, n_fidx, r_free_idx, n_free_idx, r_slot_idx, n_slot_idx;
    t_slot           r_fslot, n_fslot;
    logic [1:0]      r_l_side, n_l_side;
    logic [31:0]     r_l_px, n_l_px, r_l_qty, n_l_qty;
    logic            r_place, n_place;
    logic            r_match, n_match, r_absent, n_absent;
    logic [LAW-1:0]  r_match_idx, n_match_idx, r_absent_idx, n_absent_idx;
    logic [47:0]     r_match_tot, n_match_tot;
    t_status         r_status, n_status;
    logic            r_have_bid, n_have_bid, r_have_ask, n_have_ask;
    logic [31:0]     r_bid_px, n_bid_px, r_ask_px, n_ask_px;
    logic [47:0]     r_bid_qty, n_bid_qty, r_ask_qty, n_ask_qty;
    logic [63:0]     r_last, n_last;
    logic [7:0]      r_venue, n_venue;
    logic [31:0]     r_instr, n_instr;
    logic            r_clr_item, n_clr_item;
    logic            r_age_use, n_age_use;

    logic [CNTW-1:0] scan_n;
    logic            scanning, cnt_live, scan_done;
    t_level          lv_rd;
    logic [31:0]     used, left;
    logic [47:0]     rem_tot;
    logic [48:0]     sum;
    logic [47:0]     sat_tot;
    logic            div_start, div_busy, age_ok;
    logic [31:0]     div_q;

    logic            slot_we, bid_we, ask_we;
    logic [SAW-1:0]  slot_wa;
    logic [LAW-1:0]  lvl_wa;
    t_slot           slot_wd;
    t_level          lvl_wd;
    logic [SAW-1:0]  slot_ra;
    logic [LAW-1:0]  lvl_ra;

    // sequential table walks share one counter; read data is registered and arrives in the cycle after its address
    always_comb begin
        case (r_state)
            S_OSCAN: scan_n = CNTW'(ORDER_SLOTS);
            default: scan_n = CNTW'(PRICE_LEVELS);
        endcase
    end
    assign scanning  = r_state inside {S_OSCAN, S_LSCAN, S_BEST};
    assign cnt_live  = (r_cnt < scan_n);
    assign scan_done = !cnt_live && !r_rd_v;
    assign lv_rd     = (r_l_side == SIDE_BUY) ? bid_rd : ask_rd;

    assign used    = (r_item.qty < r_fslot.qty) ? r_item.qty : r_fslot.qty;
    assign left    = r_fslot.qty - used;
    assign rem_tot = (r_match_tot <= {16'd0, r_l_qty}) ? 48'd0
                     : r_match_tot - {16'd0, r_l_qty};
    assign sum     = {1'b0, (r_match ? r_match_tot : 48'd0)} + {17'd0, r_l_qty};
    assign sat_tot = sum[48] ? {48{1'b1}} : sum[47:0];

    assign age_ok    = (i_item.act == ACT_QUERY) && (r_last != 64'd0)
                       && (i_item.now >= r_last);
    assign o_take    = (r_state == S_IDLE) && i_valid;
    assign div_start = o_take && age_ok;

    obl_div1000 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_item.now - r_last),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    // next state
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_item       = r_item;
        n_found      = r_found;
        n_free_ok    = r_free_ok;
        n_fidx       = r_fidx;
        n_free_idx   = r_free_idx;
        n_slot_idx   = r_slot_idx;
        n_fslot      = r_fslot;
        n_l_side     = r_l_side;
        n_l_px       = r_l_px;
        n_l_qty      = r_l_qty;
        n_place      = r_place;
        n_match      = r_match;
        n_absent     = r_absent;
        n_match_idx  = r_match_idx;
        n_absent_idx = r_absent_idx;
        n_match_tot  = r_match_tot;
        n_status     = r_status;
        n_have_bid   = r_have_bid;
        n_have_ask   = r_have_ask;
        n_bid_px     = r_bid_px;
        n_bid_qty    = r_bid_qty;
        n_ask_px     = r_ask_px;
        n_ask_qty    = r_ask_qty;
        n_last       = r_last;
        n_venue      = r_venue;
        n_instr      = r_instr;
        n_clr_item   = r_clr_item;
        n_age_use    = r_age_use;

        if (scanning && cnt_live) n_cnt = r_cnt + CNTW'(1);
        if (scanning && scan_done) n_cnt = '0;

        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(MAXN - 1)) begin
                    n_cnt   = '0;
                    n_state = r_clr_item ? S_BEST : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_item     = i_item;
                    n_status   = ST_OK;
                    n_found    = 1'b0;
                    n_free_ok  = 1'b0;
                    n_match    = 1'b0;
                    n_absent   = 1'b0;
                    n_have_bid = 1'b0;
                    n_have_ask = 1'b0;
                    n_bid_px   = '0;
                    n_bid_qty  = '0;
                    n_ask_px   = '0;
                    n_ask_qty  = '0;
                    n_cnt      = '0;
                    n_age_use  = age_ok;
                    n_clr_item = 1'b0;
                    if (i_item.act != ACT_QUERY) begin
                        n_last  = i_item.now;
                        n_venue = i_item.venue;
                        n_instr = i_item.instr;
                    end
                    case (i_item.act)
                        ACT_ADD: begin
                            if (i_item.add_bad) begin
                                n_status = ST_IGNORED;
                                n_state  = S_BEST;
                            end else begin
                                n_state = S_OSCAN;
                            end
                        end
                        ACT_MODIFY, ACT_CANCEL: n_state = S_OSCAN;
                        ACT_TRADE: begin
                            if (i_item.qty_zero) begin
                                n_status = ST_IGNORED;
                                n_state  = S_BEST;
                            end else begin
                                n_state = S_OSCAN;
                            end
                        end
                        ACT_RESET: begin
                            n_clr_item = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        default: n_state = S_BEST;
                    endcase
                end
            end
            S_OSCAN: begin
                if (r_rd_v) begin
                    if (slot_rd.side != SIDE_NONE && slot_rd.ref_id == r_item.ref_id
                        && !r_found) begin
                        n_found = 1'b1;
                        n_fidx  = r_rd_idx[SAW-1:0];
                        n_fslot = slot_rd;
                    end
                    if (slot_rd.side == SIDE_NONE && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_rd_idx[SAW-1:0];
                    end
                end
                if (scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_LSCAN;
                if (r_found && r_item.act != ACT_TRADE) begin
                    // take the resting order out of its level first
                    n_l_side   = r_fslot.side;
                    n_l_px     = r_fslot.px;
                    n_l_qty    = r_fslot.qty;
                    n_place    = 1'b0;
                    n_slot_idx = r_fidx;
                end else begin
                    case (r_item.act)
                        ACT_ADD, ACT_MODIFY: begin
                            n_l_side   = r_item.side;
                            n_l_px     = r_item.px;
                            n_l_qty    = r_item.qty;
                            n_place    = 1'b1;
                            n_slot_idx = r_free_idx;
                            if (r_item.add_bad) begin
                                n_status = ST_IGNORED;
                                n_state  = S_BEST;
                            end else if (!r_free_ok) begin
                                n_status = ST_FULL;
                                n_state  = S_BEST;
                            end
                        end
                        ACT_TRADE: begin
                            n_place = 1'b0;
                            if (r_found) begin
                                n_l_side = r_fslot.side;
                                n_l_px   = r_fslot.px;
                                n_l_qty  = used;
                            end else if (r_item.side_ok && !r_item.px_zero) begin
                                n_l_side = r_item.side;
                                n_l_px   = r_item.px;
                                n_l_qty  = r_item.qty;
                            end else begin
                                n_status = ST_IGNORED;
                                n_state  = S_BEST;
                            end
                        end
                        default: begin
                            n_status = ST_IGNORED;
                            n_state  = S_BEST;
                        end
                    endcase
                end
            end
            S_LSCAN: begin
                if (r_rd_v) begin
                    if (lv_rd.total != 48'd0 && lv_rd.px == r_l_px && !r_match) begin
                        n_match     = 1'b1;
                        n_match_idx = r_rd_idx[LAW-1:0];
                        n_match_tot = lv_rd.total;
                    end
                    if (lv_rd.total == 48'd0 && !r_absent) begin
                        n_absent     = 1'b1;
                        n_absent_idx = r_rd_idx[LAW-1:0];
                    end
                end
                if (scan_done) n_state = r_place ? S_LPLACE : S_LREM;
            end
            S_LREM: begin
                n_state = S_BEST;
                case (r_item.act)
                    ACT_TRADE: begin
                        n_status = (r_found || r_match) ? ST_OK : ST_IGNORED;
                    end
                    ACT_ADD, ACT_MODIFY: begin
                        if (!(r_item.act == ACT_MODIFY && r_item.qty_zero)) begin
                            n_l_side = (r_item.act == ACT_ADD || r_item.side_ok)
                                       ? r_item.side : r_fslot.side;
                            n_l_px   = r_item.px;
                            n_l_qty  = r_item.qty;
                            n_place  = 1'b1;
                            n_match  = 1'b0;
                            n_absent = 1'b0;
                            n_state  = S_LSCAN;
                        end
                    end
                    default: n_status = ST_OK;
                endcase
            end
            S_LPLACE: begin
                n_status = (r_match || r_absent) ? ST_OK : ST_FULL;
                n_state  = S_BEST;
            end
            S_BEST: begin
                if (r_rd_v) begin
                    if (bid_rd.total != 48'd0 && (!r_have_bid || bid_rd.px > r_bid_px)) begin
                        n_have_bid = 1'b1;
                        n_bid_px   = bid_rd.px;
                        n_bid_qty  = bid_rd.total;
                    end
                    if (ask_rd.total != 48'd0 && (!r_have_ask || ask_rd.px < r_ask_px)) begin
                        n_have_ask = 1'b1;
                        n_ask_px   = ask_rd.px;
                        n_ask_qty  = ask_rd.total;
                    end
                end
                if (scan_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready && !div_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: memory ports and result
    always_comb begin
        slot_ra = r_cnt[SAW-1:0];
        lvl_ra  = r_cnt[LAW-1:0];
        slot_we = 1'b0;
        bid_we  = 1'b0;
        ask_we  = 1'b0;
        slot_wa = r_fidx;
        lvl_wa  = r_match_idx;
        slot_wd = r_fslot;
        lvl_wd  = '{px: r_l_px, total: rem_tot};
        case (r_state)
            S_CLEAR: begin
                slot_we = (r_cnt < CNTW'(ORDER_SLOTS));
                bid_we  = (r_cnt < CNTW'(PRICE_LEVELS));
                ask_we  = bid_we;
                slot_wa = r_cnt[SAW-1:0];
                lvl_wa  = r_cnt[LAW-1:0];
                slot_wd = '0;
                lvl_wd  = '0;
            end
            S_LREM: begin
                bid_we = r_match && (r_l_side == SIDE_BUY);
                ask_we = r_match && (r_l_side != SIDE_BUY);
                if (r_item.act == ACT_TRADE) begin
                    slot_we     = r_found;
                    slot_wd.qty = left;
                    if (left == 32'd0) slot_wd.side = SIDE_NONE;
                end else begin
                    slot_we      = 1'b1;
                    slot_wd.side = SIDE_NONE;
                end
            end
            S_LPLACE: begin
                bid_we  = (r_match || r_absent) && (r_l_side == SIDE_BUY);
                ask_we  = (r_match || r_absent) && (r_l_side != SIDE_BUY);
                slot_we = r_match || r_absent;
                slot_wa = r_slot_idx;
                lvl_wa  = r_match ? r_match_idx : r_absent_idx;
                lvl_wd  = '{px: r_l_px, total: sat_tot};
                slot_wd = '{ref_id: r_item.ref_id, side: r_l_side, px: r_l_px,
                            qty: r_l_qty};
            end
            default: ;
        endcase

        o_emit          = (r_state == S_EMIT) && i_res_ready && !div_busy;
        o_res.bid_px    = r_bid_px;
        o_res.bid_qty   = r_bid_qty;
        o_res.ask_px    = r_ask_px;
        o_res.ask_qty   = r_ask_qty;
        o_res.age_us    = r_age_use ? div_q : 32'd0;
        o_res.crossed   = r_have_bid && r_have_ask && (r_bid_px >= r_ask_px);
        o_res.status    = r_status;
        o_res.venue     = r_venue;
        o_res.instr     = r_instr;
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        slot_rd <= slot_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bid_we) bid_mem[lvl_wa] <= lvl_wd;
        bid_rd <= bid_mem[lvl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ask_we) ask_mem[lvl_wa] <= lvl_wd;
        ask_rd <= ask_mem[lvl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_rd_v     <= 1'b0;
            r_clr_item <= 1'b0;
            r_last     <= '0;
            r_venue    <= '0;
            r_instr    <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_rd_v     <= scanning && cnt_live;
            r_clr_item <= n_clr_item;
            r_last     <= n_last;
            r_venue    <= n_venue;
            r_instr    <= n_instr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_cnt[MAXW-1:0];
        r_item       <= n_item;
        r_found      <= n_found;
        r_free_ok    <= n_free_ok;
        r_fidx       <= n_fidx;
        r_free_idx   <= n_free_idx;
        r_slot_idx   <= n_slot_idx;
        r_fslot      <= n_fslot;
        r_l_side     <= n_l_side;
        r_l_px       <= n_l_px;
        r_l_qty      <= n_l_qty;
        r_place      <= n_place;
        r_match      <= n_match;
        r_absent     <= n_absent;
        r_match_idx  <= n_match_idx;
        r_absent_idx <= n_absent_idx;
        r_match_tot  <= n_match_tot;
        r_status     <= n_status;
        r_have_bid   <= n_have_bid;
        r_have_ask   <= n_have_ask;
        r_bid_px     <= n_bid_px;
        r_bid_qty    <= n_bid_qty;
        r_ask_px     <= n_ask_px;
        r_ask_qty    <= n_ask_qty;
        r_age_use    <= n_age_use;
    end

endmodule

@@ rtl/order_book_level_builder_top.sv @@
// Order book level builder. Feed requests (add, modify, cancel, trade, reset,
// heartbeat, quote query) go in through a two-entry request queue; each one
// produces exactly one result holding best bid and ask with their level
// totals, a crossed flag, book age in microseconds, a status and the last
// stored venue and instrument tags. Requests are worked one at a time by a
// sequencer that walks single-port tables one entry per cycle: a book
// request that hits the order table runs the order lookup walk, one or two
// level walks, then the best-price rescan; heartbeat and query run only the
// rescan (a query also waits on the age divider, which overlaps the rescan);
// a book reset runs a clearing pass over MAXN entries, where MAXN is the
// larger of the two table depths, then the rescan. After reset the block
// runs a clearing pass over MAXN entries before it takes the first request;
// push is accepted into the queue meanwhile until it fills. Results sit in
// an output register until popped, so the next request can be taken while a
// result still waits.
module order_book_level_builder_top #(
    parameter int ORDER_SLOTS  = obl_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = obl_pkg::PRICE_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_action,
    input  logic [63:0] i_order_ref,
    input  logic [1:0]  i_order_side,
    input  logic [31:0] i_price_paise,
    input  logic [31:0] i_quantity,
    input  logic [63:0] i_time_ns,
    input  logic [7:0]  i_venue_code,
    input  logic [31:0] i_instrument_code,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_best_bid_price,
    output logic [47:0] o_best_bid_qty,
    output logic [31:0] o_best_ask_price,
    output logic [47:0] o_best_ask_qty,
    output logic [31:0] o_book_age_us,
    output logic        o_is_crossed,
    output logic [1:0]  o_status,
    output logic [7:0]  o_venue_out,
    output logic [31:0] o_instrument_out
);
    import obl_pkg::*;

    logic    q_valid, q_take;
    t_item   q_item;
    logic    emit;
    t_result res;

    // result register: one waiting result, loaded when the back end finishes
    logic    r_res_valid;
    t_result r_res;

    // front end: request queue and decode
    obl_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_action          (i_action),
        .i_order_ref       (i_order_ref),
        .i_order_side      (i_order_side),
        .i_price_paise     (i_price_paise),
        .i_quantity        (i_quantity),
        .i_time_ns         (i_time_ns),
        .i_venue_code      (i_venue_code),
        .i_instrument_code (i_instrument_code),
        .o_valid           (q_valid),
        .o_item            (q_item),
        .i_take            (q_take)
    );

    // back end: table walks, book update, best-price scan
    obl_back #(
        .ORDER_SLOTS  (ORDER_SLOTS),
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_take      (q_take),
        .i_res_ready (!r_res_valid),
        .o_emit      (emit),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit) begin
            r_res_valid <= 1'b1;
        end else if (pop) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_res <= res;
    end

    assign empty            = !r_res_valid;
    assign o_best_bid_price = r_res.bid_px;
    assign o_best_bid_qty   = r_res.bid_qty;
    assign o_best_ask_price = r_res.ask_px;
    assign o_best_ask_qty   = r_res.ask_qty;
    assign o_book_age_us    = r_res.age_us;
    assign o_is_crossed     = r_res.crossed;
    assign o_status         = r_res.status;
    assign o_venue_out      = r_res.venue;
    assign o_instrument_out = r_res.instr;

endmodule
